[rtl/hsvg_pkg.sv]
// Shared types, region codes and the gamma table of the HSV to RGB pixel pipeline.
// Depends on nothing; the top level and the stage modules refer to it by scoped names.

package hsvg_pkg;

    typedef enum logic [2:0] {
        RGN_R_TO_Y = 3'd0,
        RGN_Y_TO_G = 3'd1,
        RGN_G_TO_C = 3'd2,
        RGN_C_TO_B = 3'd3,
        RGN_B_TO_M = 3'd4,
        RGN_M_TO_R = 3'd5
    } region_t;

    localparam logic [7:0] HUE_SPAN = 8'd43;
    localparam logic [3:0] DIM_MAX  = 4'd8;

    typedef struct packed {
        region_t    region;
        logic [7:0] rem;
        logic [7:0] sat;
        logic [7:0] val;
        logic       gray;
    } region_t_s_t;

    typedef struct packed {
        region_t    region;
        logic [7:0] sat_rem;
        logic [7:0] sat_inv_rem;
        logic [7:0] p;
        logic [7:0] val;
        logic       gray;
    } scale_t;

    typedef struct packed {
        region_t    region;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
        logic [7:0] val;
        logic       gray;
    } level_t;

    localparam logic [7:0] GAMMA_LUT [0:255] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd6,
        8'd6, 8'd6, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd9,
        8'd9, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd12,
        8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
        8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd21,
        8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25, 8'd26,
        8'd26, 8'd27, 8'd28, 8'd28, 8'd29, 8'd30, 8'd30, 8'd31,
        8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36, 8'd37,
        8'd38, 8'd38, 8'd39, 8'd40, 8'd41, 8'd41, 8'd42, 8'd43,
        8'd44, 8'd45, 8'd46, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50,
        8'd51, 8'd52, 8'd53, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57,
        8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65,
        8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73,
        8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81,
        8'd82, 8'd83, 8'd84, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90,
        8'd91, 8'd92, 8'd93, 8'd95, 8'd96, 8'd97, 8'd98, 8'd99,
        8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109,
        8'd110, 8'd111, 8'd113, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119,
        8'd120, 8'd122, 8'd123, 8'd124, 8'd126, 8'd127, 8'd128, 8'd129,
        8'd131, 8'd132, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139, 8'd140,
        8'd142, 8'd143, 8'd145, 8'd146, 8'd147, 8'd149, 8'd150, 8'd152,
        8'd153, 8'd154, 8'd156, 8'd157, 8'd159, 8'd160, 8'd162, 8'd163,
        8'd165, 8'd166, 8'd168, 8'd169, 8'd171, 8'd172, 8'd174, 8'd175,
        8'd177, 8'd178, 8'd180, 8'd181, 8'd183, 8'd184, 8'd186, 8'd188,
        8'd189, 8'd191, 8'd192, 8'd194, 8'd195, 8'd197, 8'd199, 8'd200,
        8'd202, 8'd204, 8'd205, 8'd207, 8'd208, 8'd210, 8'd212, 8'd213,
        8'd215, 8'd217, 8'd218, 8'd220, 8'd222, 8'd224, 8'd225, 8'd227,
        8'd229, 8'd230, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd241,
        8'd243, 8'd244, 8'd246, 8'd248, 8'd250, 8'd251, 8'd253, 8'd255
    };

    function automatic logic [7:0] gamma_lookup(input logic [7:0] x);
        return GAMMA_LUT[x];
    endfunction

endpackage

[rtl/hsvg_hsv_if.sv]
// Request channel carrying one HSV pixel with a valid/ready handshake.
// Standalone; used by the top level and the region stage.

interface hsvg_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;

    modport source (output valid, output hue, output saturation, output value, input ready);
    modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

[rtl/hsvg_rgb_if.sv]
// Request channel carrying one gamma corrected RGB pixel with a valid/ready handshake.
// Standalone; used by the top level and the output stage.

interface hsvg_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/hsv_to_rgb_gamma_pixel_top.sv]
// Top level of the HSV to RGB pixel converter with dimming and gamma correction.
// Depends on hsvg_pkg, both channel interfaces and the four pipeline stage modules.
//
// Channel   Dir  Payload                     Handshake
// hsv       in   hue, saturation, value      valid/ready
// rgb       out  red, green, blue            valid/ready
// cfg       in   cfg_write_data (dim shift)  cfg_write_en, no ready
//
// Four register stages: region, saturation products, value products, select and gamma.
// Pixels pass region, scale, level and out registers; one pixel per cycle unless rgb stalls.
// Reset clears all stage valid bits and sets the dim shift to zero.
// A stall on rgb freezes only the occupied stages; empty stages keep accepting.

module hsv_to_rgb_gamma_pixel_top
(
    input  logic       clk,
    input  logic       rst_n,
    hsvg_hsv_if.sink   hsv,
    hsvg_rgb_if.source rgb,
    input  logic       cfg_write_en,
    input  logic [3:0] cfg_write_data
);

    logic                  dim_shift_reg;
    logic [3:0]            dim_shift_q_reg;
    logic                  region_valid;
    logic                  scale_valid;
    logic                  scale_ready;
    logic                  level_valid;
    logic                  level_ready;
    logic                  out_ready;
    hsvg_pkg::region_t_s_t region_data;
    hsvg_pkg::scale_t      scale_data;
    hsvg_pkg::level_t      level_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_shift_q_reg <= 4'd0;
            dim_shift_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            dim_shift_q_reg <= cfg_write_data;
            dim_shift_reg   <= 1'b1;
        end
    end

    hsvg_region u_region
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv       (hsv),
        .ready_out (scale_ready),
        .valid_out (region_valid),
        .data_out  (region_data)
    );

    hsvg_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (region_valid),
        .ready_in  (scale_ready),
        .data_in   (region_data),
        .ready_out (level_ready),
        .valid_out (scale_valid),
        .data_out  (scale_data)
    );

    hsvg_level u_level
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (scale_valid),
        .ready_in  (level_ready),
        .data_in   (scale_data),
        .ready_out (out_ready),
        .valid_out (level_valid),
        .data_out  (level_data)
    );

    hsvg_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (level_valid),
        .ready_in  (out_ready),
        .data_in   (level_data),
        .dim_shift (dim_shift_q_reg),
        .rgb       (rgb)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !hsv.ready |-> (rgb.valid && !rgb.ready && region_valid && scale_valid && level_valid))
    else $error("Input backpressure without a fully stalled pipeline.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !dim_shift_reg |-> (dim_shift_q_reg == 4'd0))
    else $error("Dim shift changed without a configuration write.");

endmodule

[rtl/hsvg_region.sv]
// First pipeline stage: hue region and scaled remainder, gray detection.
// Depends on hsvg_pkg and hsvg_hsv_if.

module hsvg_region
(
    input  logic                 clk,
    input  logic                 rst_n,
    hsvg_hsv_if.sink             hsv,
    input  logic                 ready_out,
    output logic                 valid_out,
    output hsvg_pkg::region_t_s_t data_out
);

    logic                  valid_reg;
    hsvg_pkg::region_t_s_t data_reg;
    hsvg_pkg::region_t_s_t data_next;
    hsvg_pkg::region_t     region;
    logic [7:0]            base;
    logic [5:0]            offset;
    logic [7:0]            offset_wide;

    always_comb
    begin
        if (hsv.hue >= 8'(5 * hsvg_pkg::HUE_SPAN))
        begin
            region = hsvg_pkg::RGN_M_TO_R;
            base   = 8'(5 * hsvg_pkg::HUE_SPAN);
        end
        else if (hsv.hue >= 8'(4 * hsvg_pkg::HUE_SPAN))
        begin
            region = hsvg_pkg::RGN_B_TO_M;
            base   = 8'(4 * hsvg_pkg::HUE_SPAN);
        end
        else if (hsv.hue >= 8'(3 * hsvg_pkg::HUE_SPAN))
        begin
            region = hsvg_pkg::RGN_C_TO_B;
            base   = 8'(3 * hsvg_pkg::HUE_SPAN);
        end
        else if (hsv.hue >= 8'(2 * hsvg_pkg::HUE_SPAN))
        begin
            region = hsvg_pkg::RGN_G_TO_C;
            base   = 8'(2 * hsvg_pkg::HUE_SPAN);
        end
        else if (hsv.hue >= hsvg_pkg::HUE_SPAN)
        begin
            region = hsvg_pkg::RGN_Y_TO_G;
            base   = hsvg_pkg::HUE_SPAN;
        end
        else
        begin
            region = hsvg_pkg::RGN_R_TO_Y;
            base   = 8'd0;
        end
        offset_wide = hsv.hue - base;
        offset      = offset_wide[5:0];

        data_next.region = region;
        data_next.rem    = 8'({2'b00, offset} * 8'd6);
        data_next.sat    = hsv.saturation;
        data_next.val    = hsv.value;
        data_next.gray   = (hsv.saturation == 8'd0);
    end

    assign hsv.ready = !valid_reg || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hsv.ready)
        begin
            valid_reg <= hsv.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hsv.ready && hsv.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.region <= hsvg_pkg::RGN_M_TO_R) && (data_reg.rem <= 8'd252))
    else $error("Region stage holds a region or remainder out of range.");

endmodule

[rtl/hsvg_scale.sv]
// Second pipeline stage: saturation products and the p level.
// Depends on hsvg_pkg.

module hsvg_scale
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    output logic                  ready_in,
    input  hsvg_pkg::region_t_s_t data_in,
    input  logic                  ready_out,
    output logic                  valid_out,
    output hsvg_pkg::scale_t      data_out
);

    logic             valid_reg;
    hsvg_pkg::scale_t data_reg;
    hsvg_pkg::scale_t data_next;
    logic [15:0]      prod_rem;
    logic [15:0]      prod_inv_rem;
    logic [15:0]      prod_p;

    always_comb
    begin
        prod_rem     = data_in.sat * data_in.rem;
        prod_inv_rem = data_in.sat * 8'(~data_in.rem);
        prod_p       = data_in.val * 8'(~data_in.sat);

        data_next.region      = data_in.region;
        data_next.sat_rem     = prod_rem[15:8];
        data_next.sat_inv_rem = prod_inv_rem[15:8];
        data_next.p           = prod_p[15:8];
        data_next.val         = data_in.val;
        data_next.gray        = data_in.gray;
    end

    assign ready_in = !valid_reg || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.p <= data_reg.val))
    else $error("The p level exceeds the pixel value.");

endmodule

[rtl/hsvg_level.sv]
// Third pipeline stage: the q and t levels scaled by value.
// Depends on hsvg_pkg.

module hsvg_level
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    output logic             ready_in,
    input  hsvg_pkg::scale_t data_in,
    input  logic             ready_out,
    output logic             valid_out,
    output hsvg_pkg::level_t data_out
);

    logic             valid_reg;
    hsvg_pkg::level_t data_reg;
    hsvg_pkg::level_t data_next;
    logic [15:0]      prod_q;
    logic [15:0]      prod_t;

    always_comb
    begin
        prod_q = data_in.val * 8'(~data_in.sat_rem);
        prod_t = data_in.val * 8'(~data_in.sat_inv_rem);

        data_next.region = data_in.region;
        data_next.p      = data_in.p;
        data_next.q      = prod_q[15:8];
        data_next.t      = prod_t[15:8];
        data_next.val    = data_in.val;
        data_next.gray   = data_in.gray;
    end

    assign ready_in = !valid_reg || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.q <= data_reg.val) && (data_reg.t <= data_reg.val))
    else $error("The q or t level exceeds the pixel value.");

endmodule

[rtl/hsvg_out.sv]
// Last pipeline stage: channel selection by region or gray, dimming, gamma lookup, output register.
// Depends on hsvg_pkg and hsvg_rgb_if.

module hsvg_out
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    output logic             ready_in,
    input  hsvg_pkg::level_t data_in,
    input  logic [3:0]       dim_shift,
    hsvg_rgb_if.source       rgb
);

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] red_sel;
    logic [7:0] green_sel;
    logic [7:0] blue_sel;
    logic       dim_off;

    always_comb
    begin
        if (data_in.gray)
        begin
            red_sel   = data_in.val;
            green_sel = data_in.val;
            blue_sel  = data_in.val;
        end
        else
        begin
            unique case (data_in.region)
                hsvg_pkg::RGN_R_TO_Y:
                begin
                    red_sel   = data_in.val;
                    green_sel = data_in.t;
                    blue_sel  = data_in.p;
                end
                hsvg_pkg::RGN_Y_TO_G:
                begin
                    red_sel   = data_in.q;
                    green_sel = data_in.val;
                    blue_sel  = data_in.p;
                end
                hsvg_pkg::RGN_G_TO_C:
                begin
                    red_sel   = data_in.p;
                    green_sel = data_in.val;
                    blue_sel  = data_in.t;
                end
                hsvg_pkg::RGN_C_TO_B:
                begin
                    red_sel   = data_in.p;
                    green_sel = data_in.q;
                    blue_sel  = data_in.val;
                end
                hsvg_pkg::RGN_B_TO_M:
                begin
                    red_sel   = data_in.t;
                    green_sel = data_in.p;
                    blue_sel  = data_in.val;
                end
                hsvg_pkg::RGN_M_TO_R:
                begin
                    red_sel   = data_in.val;
                    green_sel = data_in.p;
                    blue_sel  = data_in.q;
                end
                default:
                begin
                    red_sel   = 8'd0;
                    green_sel = 8'd0;
                    blue_sel  = 8'd0;
                end
            endcase
        end

        dim_off    = (dim_shift >= hsvg_pkg::DIM_MAX);
        red_next   = hsvg_pkg::gamma_lookup(dim_off ? 8'd0 : (red_sel >> dim_shift[2:0]));
        green_next = hsvg_pkg::gamma_lookup(dim_off ? 8'd0 : (green_sel >> dim_shift[2:0]));
        blue_next  = hsvg_pkg::gamma_lookup(dim_off ? 8'd0 : (blue_sel >> dim_shift[2:0]));
    end

    assign ready_in = !valid_reg || rgb.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule
